// ----- design/rle_mask_to_rgba_decoder_top_macros.svh -----
// Assertion macros shared by the decoder modules.
// Each macro expects the enclosing module to have aclk and aresetn.
`ifndef RLE_MASK_TO_RGBA_DECODER_TOP_MACROS_SVH
`define RLE_MASK_TO_RGBA_DECODER_TOP_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define RMRGBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition never holds outside reset.
`define RMRGBA_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ----- design/rmrgba_pkg.sv -----
package rmrgba_pkg;

    // Item actions.
    localparam logic ACT_STREAM  = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    // Pixel depth modes.
    localparam logic [1:0] DEPTH_PALETTE = 2'd1;
    localparam logic [1:0] DEPTH_RGB565  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int unsigned COLOR_BITS = 24;
    localparam int unsigned COUNT_BITS = 7;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'd255;
    localparam logic [7:0]  ALPHA_TRANSPARENT = 8'd0;

    typedef struct packed {
        logic                  action;
        logic [7:0]            stream_byte;
        logic [7:0]            palette_index;
        logic [COLOR_BITS-1:0] palette_color;
    } in_item_t;

    typedef struct packed {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [7:0]            alpha;
        logic [COUNT_BITS-1:0] repeat_count;
        logic                  image_done;
    } out_item_t;

endpackage

// ----- design/rmrgba_ram.sv -----
module rmrgba_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rmrgba_core.sv -----
`include "rle_mask_to_rgba_decoder_top_macros.svh"

module rmrgba_core #(
    parameter int unsigned DIM_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [1:0]                      depth_mode,
    input  logic [DIM_BITS-1:0]             image_width,
    input  logic [DIM_BITS-1:0]             image_height,
    input  logic                            step,
    input  rmrgba_pkg::in_item_t            item,
    input  logic [rmrgba_pkg::COLOR_BITS-1:0] pal_color,
    input  logic                            pal_hit,
    output logic                            res_valid,
    output rmrgba_pkg::out_item_t           res
);

    // Columns can overshoot the width by up to one full count before wrapping.
    localparam int unsigned COL_BITS = DIM_BITS + 8;
    localparam int unsigned CB = rmrgba_pkg::COUNT_BITS;

    logic [COL_BITS-1:0] column_reg, column_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [CB-1:0]       literals_reg, literals_next;
    logic [7:0]          low_hold_reg, low_hold_next;
    logic                phase_reg, phase_next;
    logic                finished_reg, finished_next;

    logic                stream_step;
    logic                ignore;
    logic [7:0]          b;
    logic [CB-1:0]       cnt;
    logic [CB-1:0]       lit_dec;
    logic                depth_ok;
    logic                do_col;
    logic                do_end;
    logic [CB-1:0]       col_add;
    logic [COL_BITS-1:0] col_sum;
    logic                wrap;
    logic [DIM_BITS-1:0] row_inc;
    logic                img_end;
    logic                emit;
    logic [15:0]         word;

    assign stream_step = step && (item.action == rmrgba_pkg::ACT_STREAM);
    assign b        = item.stream_byte;
    assign cnt      = b[CB-1:0];
    assign lit_dec  = literals_reg - CB'(1);
    assign depth_ok = (depth_mode == rmrgba_pkg::DEPTH_PALETTE) ||
                      (depth_mode == rmrgba_pkg::DEPTH_RGB565);
    assign ignore   = finished_reg || (image_width == '0) || (row_reg >= image_height);
    assign word     = {b, low_hold_reg};

    // Shared column advance and end of group check.
    assign col_sum = column_reg + COL_BITS'(col_add);
    assign wrap    = do_end && (col_sum >= COL_BITS'(image_width));
    assign row_inc = row_reg + DIM_BITS'(1);
    assign img_end = wrap && (row_inc >= image_height);

    always_comb begin
        literals_next = literals_reg;
        low_hold_next = low_hold_reg;
        phase_next    = phase_reg;
        do_col        = 1'b0;
        do_end        = 1'b0;
        col_add       = CB'(1);
        emit          = 1'b0;
        res           = '0;
        res.image_done = img_end;

        if (stream_step && !ignore) begin
            if (literals_reg == '0) begin
                if (cnt != '0) begin
                    if (b[7] || !depth_ok) begin
                        // Transparent run, or literals of an unusable depth.
                        col_add = cnt;
                        do_col  = 1'b1;
                        do_end  = 1'b1;
                        emit    = b[7];
                        res.repeat_count = cnt;
                    end else begin
                        literals_next = cnt;
                        phase_next    = 1'b0;
                    end
                end
            end else if (depth_mode == rmrgba_pkg::DEPTH_RGB565 && !phase_reg) begin
                low_hold_next = b;
                phase_next    = 1'b1;
            end else begin
                phase_next    = 1'b0;
                literals_next = lit_dec;
                do_col        = 1'b1;
                do_end        = (lit_dec == '0);
                emit          = depth_ok;
                res.repeat_count = CB'(1);
                if (depth_mode == rmrgba_pkg::DEPTH_PALETTE) begin
                    if (pal_hit) begin
                        res.red   = pal_color[23:16];
                        res.green = pal_color[15:8];
                        res.blue  = pal_color[7:0];
                    end
                    res.alpha = (b != 8'd0) ? rmrgba_pkg::ALPHA_OPAQUE
                                            : rmrgba_pkg::ALPHA_TRANSPARENT;
                end else begin
                    res.red   = {word[15:11], 3'b000};
                    res.green = {word[10:5], 2'b00};
                    res.blue  = {word[4:0], 3'b000};
                    res.alpha = (word != 16'd0) ? rmrgba_pkg::ALPHA_OPAQUE
                                                : rmrgba_pkg::ALPHA_TRANSPARENT;
                end
            end
        end
    end

    always_comb begin
        column_next   = column_reg;
        row_next      = row_reg;
        finished_next = finished_reg;
        if (do_col) begin
            column_next = wrap ? '0 : col_sum;
        end
        if (wrap) begin
            row_next = row_inc;
        end
        if (img_end) begin
            finished_next = 1'b1;
        end
    end

    assign res_valid = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            row_reg      <= '0;
            literals_reg <= '0;
            low_hold_reg <= '0;
            phase_reg    <= 1'b0;
            finished_reg <= 1'b0;
        end else begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            literals_reg <= literals_next;
            low_hold_reg <= low_hold_next;
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
        end
    end

    `RMRGBA_NEVER(a_no_result_after_finish, finished_reg && res_valid, "result after image end")
    `RMRGBA_ASSERT(a_done_sets_finish, res_valid && res.image_done |=> finished_reg, "finish not set")
    `RMRGBA_NEVER(a_phase_needs_literal, phase_reg && (literals_reg == '0), "half word with no literal")

endmodule

// ----- design/rle_mask_to_rgba_decoder_top.sv -----
// Run-length mask decoder: turns a compressed mask byte stream into RGBA pixels.
//
// Input channel (s_valid / s_ready / s_item): each beat is either one stream
// byte (action 0) or one palette entry write (action 1). Palette writes land in
// the palette memory as the beat is accepted, so a stream byte in the very next
// beat already sees the new color.
// Result channel (m_valid / m_ready / m_item): one beat per emitted pixel run;
// literal control bytes, low bytes of RGB565 words and ignored bytes make no beat.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata): depth mode, width and
// height, written while the decoder is idle; writes never reset the counters.
//
// An accepted beat loads the input register and the palette read; the decode
// step then loads its result into the output register, which drives m_valid.
// Throughput is one beat per cycle while the receiver keeps taking results,
// set by the single decode step between those registers. When the receiver
// stalls, the output register holds its beat and the input register fills;
// s_ready drops only once both are occupied. Reset clears the counters, the
// flags and both valid bits; the palette memory is not cleared and must be
// loaded before use.
`include "rle_mask_to_rgba_decoder_top_macros.svh"

module rle_mask_to_rgba_decoder_top #(
    parameter int unsigned PALETTE_ENTRIES = 256,
    parameter int unsigned DIM_BITS        = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rmrgba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]                   cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rmrgba_pkg::in_item_t                  s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rmrgba_pkg::out_item_t                 m_item
);

    localparam int unsigned PAL_ADDR_BITS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Configuration registers.
    logic [1:0]          depth_mode_reg;
    logic [DIM_BITS-1:0] image_width_reg;
    logic [DIM_BITS-1:0] image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_mode_reg   <= rmrgba_pkg::DEPTH_PALETTE;
            image_width_reg  <= '0;
            image_height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rmrgba_pkg::CFG_DEPTH_MODE:   depth_mode_reg   <= cfg_wdata[1:0];
                rmrgba_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                rmrgba_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: the decode step fires when the output register is free
    // or is being emptied in this cycle.
    logic                  stage_valid_reg, stage_valid_next;
    rmrgba_pkg::in_item_t  stage_item_reg;
    logic                  stage_hit_reg;
    logic                  out_valid_reg, out_valid_next;
    rmrgba_pkg::out_item_t out_item_reg;
    logic                  advance;
    logic                  s_accept;
    logic                  step;

    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !stage_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign step     = stage_valid_reg && advance;

    // Palette memory: written and read at accept time.
    logic                                  pal_wr_en;
    logic                                  wr_in_range;
    logic                                  rd_in_range;
    logic [rmrgba_pkg::COLOR_BITS-1:0]     pal_rd_data;

    assign wr_in_range = {1'b0, s_item.palette_index} < 9'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, s_item.stream_byte} < 9'(PALETTE_ENTRIES);
    assign pal_wr_en   = s_accept && (s_item.action == rmrgba_pkg::ACT_PALETTE) && wr_in_range;

    rmrgba_ram #(
        .WIDTH (rmrgba_pkg::COLOR_BITS),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (s_item.palette_index[PAL_ADDR_BITS-1:0]),
        .wr_data (s_item.palette_color),
        .rd_en   (s_accept),
        .rd_addr (s_item.stream_byte[PAL_ADDR_BITS-1:0]),
        .rd_data (pal_rd_data)
    );

    // Input register.
    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_accept) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_item_reg <= s_item;
            stage_hit_reg  <= rd_in_range;
        end
    end

    // Decode step.
    logic                  core_valid;
    rmrgba_pkg::out_item_t core_res;

    rmrgba_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .depth_mode   (depth_mode_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .step         (step),
        .item         (stage_item_reg),
        .pal_color    (pal_rd_data),
        .pal_hit      (stage_hit_reg),
        .res_valid    (core_valid),
        .res          (core_res)
    );

    // Output register.
    assign out_valid_next = advance ? core_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_valid) begin
            out_item_reg <= core_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    `RMRGBA_ASSERT(a_palette_no_result,
        step && (stage_item_reg.action == rmrgba_pkg::ACT_PALETTE) |=> !out_valid_reg,
        "palette write made a result")
    `RMRGBA_ASSERT(a_ready_low_only_full,
        !s_ready |-> stage_valid_reg && out_valid_reg && !m_ready,
        "input stalled while space free")
    `RMRGBA_ASSERT(a_idle_stage_no_result,
        !stage_valid_reg && !out_valid_reg |=> !out_valid_reg,
        "result from empty pipeline")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the run-length mask decoder. A beat-level model of the decode
// (palette, column and row counters, literal and RGB565 byte tracking) predicts
// every pixel beat. A checker compares each accepted result beat, field by
// field, with the oldest prediction. Both channels idle and stall at random.
module tb;

    localparam int unsigned DIM_SPAN   = 4096;
    localparam int unsigned RAND_ITEMS = 700;

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [rmrgba_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [11:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    rmrgba_pkg::in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    rmrgba_pkg::out_item_t m_item;

    rle_mask_to_rgba_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // Decoder model state, mirroring the block after reset.
    logic [1:0]  cfg_depth  = rmrgba_pkg::DEPTH_PALETTE;
    logic [11:0] cfg_width  = '0;
    logic [11:0] cfg_height = '0;
    logic [23:0] pal_mem [256];
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    int unsigned lits_pending = 0;
    logic [7:0]  low_hold     = '0;
    bit          phase_hi     = 0;
    bit          img_finished = 0;

    rmrgba_pkg::out_item_t pixel_q[$];
    int unsigned errors       = 0;
    int unsigned beats_sent   = 0;
    int unsigned pal_writes   = 0;
    int unsigned pixels_seen  = 0;
    int unsigned done_seen    = 0;
    bit          no_idle      = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // Closes a group of pixels: wraps the column into the next row once the
    // width is reached, and flags the image as done after the last row.
    function automatic bit close_group();
        if (col_pos >= cfg_width) begin
            col_pos = 0;
            row_pos = (row_pos + 1) % DIM_SPAN;
            if (row_pos >= cfg_height) begin
                img_finished = 1;
                return 1;
            end
        end
        return 0;
    endfunction

    // Advances the model by one accepted input beat and queues the pixel it makes.
    task automatic decode_beat(input rmrgba_pkg::in_item_t it);
        rmrgba_pkg::out_item_t px;
        logic [7:0]  sb;
        logic [6:0]  cnt;
        logic [15:0] word;
        px  = '0;
        sb  = it.stream_byte;
        cnt = sb[6:0];
        if (it.action == rmrgba_pkg::ACT_PALETTE) begin
            pal_mem[it.palette_index] = it.palette_color;
            return;
        end
        if (img_finished || cfg_width == 0 || row_pos >= cfg_height)
            return;
        if (lits_pending == 0) begin
            if (cnt == 0)
                return;
            if (sb[7]) begin
                col_pos += cnt;
                px.alpha        = rmrgba_pkg::ALPHA_TRANSPARENT;
                px.repeat_count = cnt;
                px.image_done   = close_group();
                pixel_q.push_back(px);
                return;
            end
            if (cfg_depth != rmrgba_pkg::DEPTH_PALETTE &&
                cfg_depth != rmrgba_pkg::DEPTH_RGB565) begin
                // Unknown depth: the literals are skipped without reading any bytes.
                col_pos += cnt;
                void'(close_group());
                return;
            end
            lits_pending = cnt;
            phase_hi     = 0;
            return;
        end
        if (cfg_depth == rmrgba_pkg::DEPTH_RGB565 && !phase_hi) begin
            low_hold = sb;
            phase_hi = 1;
            return;
        end
        phase_hi = 0;
        lits_pending--;
        col_pos++;
        if (cfg_depth == rmrgba_pkg::DEPTH_PALETTE) begin
            {px.red, px.green, px.blue} = pal_mem[sb];
            px.alpha = (sb != 0) ? rmrgba_pkg::ALPHA_OPAQUE : rmrgba_pkg::ALPHA_TRANSPARENT;
        end else if (cfg_depth == rmrgba_pkg::DEPTH_RGB565) begin
            word     = {sb, low_hold};
            px.red   = {word[15:11], 3'b000};
            px.green = {word[10:5], 2'b00};
            px.blue  = {word[4:0], 3'b000};
            px.alpha = (word != 0) ? rmrgba_pkg::ALPHA_OPAQUE : rmrgba_pkg::ALPHA_TRANSPARENT;
        end else begin
            // Unknown depth while literals pend: the byte ends a literal silently.
            if (lits_pending == 0)
                void'(close_group());
            return;
        end
        px.repeat_count = 1;
        px.image_done   = (lits_pending == 0) ? close_group() : 1'b0;
        pixel_q.push_back(px);
    endtask

    function automatic rmrgba_pkg::in_item_t stream_item(input logic [7:0] b);
        rmrgba_pkg::in_item_t it;
        it               = '0;
        it.action        = rmrgba_pkg::ACT_STREAM;
        it.stream_byte   = b;
        it.palette_index = 8'($urandom);
        it.palette_color = 24'($urandom);
        return it;
    endfunction

    function automatic rmrgba_pkg::in_item_t palette_item(input logic [7:0] idx,
                                                          input logic [23:0] rgb);
        rmrgba_pkg::in_item_t it;
        it               = '0;
        it.action        = rmrgba_pkg::ACT_PALETTE;
        it.stream_byte   = 8'($urandom);
        it.palette_index = idx;
        it.palette_color = rgb;
        return it;
    endfunction

    // Sends one beat, starting and ending at a falling edge. With no gap drawn,
    // valid simply stays high into the next beat.
    task automatic send_beat(input rmrgba_pkg::in_item_t it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_beat(it);
        beats_sent++;
        if (it.action == rmrgba_pkg::ACT_PALETTE)
            pal_writes++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(stream_item(b));
    endtask

    // Waits until every predicted pixel has arrived, then lets the pipeline run
    // dry of beats that make no pixel.
    task automatic settle();
        s_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rmrgba_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [11:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            rmrgba_pkg::CFG_DEPTH_MODE:   cfg_depth  = val[1:0];
            rmrgba_pkg::CFG_IMAGE_WIDTH:  cfg_width  = val;
            rmrgba_pkg::CFG_IMAGE_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    // One well-formed group most of the time: a run, or a literal control byte
    // followed by its pixel bytes with palette writes mixed in. Now and then the
    // group is cut short or a stray byte is sent instead.
    task automatic send_group();
        int unsigned n;
        int unsigned len;
        int unsigned k;
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte({1'b1, 7'($urandom_range(0, 127))});
            return;
        end
        if ($urandom_range(0, 19) == 0)
            n = $urandom_range(9, 127);
        else
            n = $urandom_range(1, 8);
        send_byte({1'b0, 7'(n)});
        len = (cfg_depth == rmrgba_pkg::DEPTH_RGB565) ? 2 * n : n;
        if ($urandom_range(0, 11) == 0)
            len = $urandom_range(0, len);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(palette_item(8'($urandom), 24'($urandom)));
            send_byte(8'($urandom));
        end
    endtask

    // Fills every palette entry so that no pixel ever reads an unwritten one.
    task automatic load_palette();
        int unsigned i;
        for (i = 0; i < 256; i++) begin
            if (i == 1)
                send_beat(palette_item(8'(i), 24'h000000));
            else if (i == 255)
                send_beat(palette_item(8'(i), 24'hFFFFFF));
            else
                send_beat(palette_item(8'(i), 24'($urandom)));
        end
    endtask

    // Straight out of reset the width is 0, so stream bytes are dropped.
    task automatic test_reset_config();
        send_byte(8'h85);
        send_byte(8'h02);
        send_byte(8'h07);
        settle();
    endtask

    task automatic test_palette_pixels();
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_PALETTE});
        write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, 12'd8);
        write_reg(rmrgba_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        send_byte(8'h00);   // zero literal count
        send_byte(8'h80);   // zero run
        send_byte(8'h83);
        send_byte(8'hFF);   // longest run, overshoots the width
        send_byte(8'h03);
        send_byte(8'h00);   // index 0 is transparent
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'h02);
        // A palette write is visible to the very next stream byte.
        send_beat(palette_item(8'h11, 24'hFFFFFF));
        send_byte(8'h11);
        send_beat(palette_item(8'h11, 24'h000000));
        send_byte(8'h11);
        settle();
    endtask

    task automatic test_rgb565_pixels();
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_RGB565});
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h00);   // word 0 is transparent
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h1F);
        // Depth drops to palette mode between the two bytes of a word.
        send_byte(8'h01);
        send_byte(8'h34);
        settle();
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_PALETTE});
        send_byte(8'h07);
        settle();
    endtask

    task automatic test_bad_depth();
        // Literal control byte with an unknown depth: column moves, no pixel.
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, 12'd3);
        send_byte(8'h05);
        send_byte(8'h7F);
        settle();
        // Unknown depth while literals are still pending.
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_PALETTE});
        send_byte(8'h03);
        send_byte(8'h42);
        settle();
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, 12'd0);
        send_byte(8'h44);
        send_byte(8'h45);
        settle();
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_PALETTE});
        send_byte(8'h81);
        settle();
    endtask

    task automatic test_dimensions();
        write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, 12'd0);
        send_byte(8'h81);
        settle();
        write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, 12'd4095);
        send_byte(8'hFF);
        send_byte(8'hC0);
        settle();
        write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, 12'd1);
        write_reg(rmrgba_pkg::CFG_IMAGE_HEIGHT, 12'd0);
        send_byte(8'h81);
        settle();
        write_reg(rmrgba_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        send_byte(8'h81);
        settle();
    endtask

    // Phases of random groups, each under a fresh depth and width. The height
    // stays at its maximum so the image cannot end before the final test.
    task automatic test_random_stream();
        int unsigned sent;
        int unsigned phase_start;
        int unsigned pick;
        logic [1:0]  depth;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            settle();
            no_idle = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 7);
            depth   = (pick == 0) ? 2'($urandom_range(0, 1) * 3) :
                      (pick < 4) ? rmrgba_pkg::DEPTH_PALETTE : rmrgba_pkg::DEPTH_RGB565;
            write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'($urandom), depth});
            pick = $urandom_range(0, 7);
            write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, (pick == 0) ? 12'd1 :
                                                   (pick == 1) ? 12'd4095 :
                                                   12'($urandom_range(2, 64)));
            phase_start = beats_sent;
            while (beats_sent - phase_start < 100)
                send_group();
            sent += beats_sent - phase_start;
        end
        settle();
        no_idle = 0;
    endtask

    // Runs the image to its end, then checks that later bytes are dropped.
    task automatic test_image_end();
        int unsigned guard;
        int unsigned k;
        write_reg(rmrgba_pkg::CFG_DEPTH_MODE, {10'b0, rmrgba_pkg::DEPTH_PALETTE});
        write_reg(rmrgba_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(rmrgba_pkg::CFG_IMAGE_HEIGHT, 12'(row_pos + 2));
        guard = 0;
        while (!img_finished && guard < 200) begin
            send_group();
            guard++;
        end
        for (k = 0; k < 6; k++)
            send_byte(8'($urandom));
        send_beat(palette_item(8'($urandom), 24'($urandom)));
        send_byte(8'h81);
        send_byte(8'h01);
        send_byte(8'h05);
        settle();
    endtask

    // Result side: holds m_ready low at random before each beat.
    initial begin : result_sink
        int unsigned hold;
        hold    = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            m_ready = (hold == 0);
            @(posedge aclk);
            if (m_valid && m_ready)
                hold = no_idle ? 0 : $urandom_range(0, 4);
            else if (m_valid && hold != 0)
                hold--;
        end
    end

    always @(posedge aclk) begin : check_results
        rmrgba_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            pixels_seen++;
            if (m_item.image_done)
                done_seen++;
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected pixel beat, red", m_item.red, 0);
            end else begin
                want = pixel_q.pop_front();
                if (m_item.red !== want.red)
                    report_mismatch("red", m_item.red, want.red);
                if (m_item.green !== want.green)
                    report_mismatch("green", m_item.green, want.green);
                if (m_item.blue !== want.blue)
                    report_mismatch("blue", m_item.blue, want.blue);
                if (m_item.alpha !== want.alpha)
                    report_mismatch("alpha", m_item.alpha, want.alpha);
                if (m_item.repeat_count !== want.repeat_count)
                    report_mismatch("repeat_count", m_item.repeat_count, want.repeat_count);
                if (m_item.image_done !== want.image_done)
                    report_mismatch("image_done", m_item.image_done, want.image_done);
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        load_palette();
        test_reset_config();
        test_palette_pixels();
        test_rgb565_pixels();
        test_bad_depth();
        test_dimensions();
        test_random_stream();
        test_image_end();

        repeat (10) @(negedge aclk);
        if (pixel_q.size() != 0)
            report_mismatch("pixel beats never delivered", 0, pixel_q.size());
        $display("Covered %0d input beats (%0d palette writes), %0d pixel beats checked.",
                 beats_sent, pal_writes, pixels_seen);
        $display("Image-done beats seen: %0d; decoder finished the image: %0d.",
                 done_seen, img_finished);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d pixel beats still outstanding.", pixel_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
